/* hdl/adf_pkg.sv */
// ----------------------------------------------------------------------------
// adf_pkg
// shared types, character codes and fraction table for the decimal to
// Q15.16 converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

  localparam int unsigned MAX_FRACTION_DIGITS = 6;
  localparam int unsigned TABLE_LEN           = 9;

  localparam logic [14:0] WHOLE_LIMIT = 15'd32767;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0] MAX_MAG     = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EOD   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] STOP_OTHER = 2'd0;
  localparam logic [1:0] STOP_SLASH = 2'd1;
  localparam logic [1:0] STOP_NL    = 2'd2;
  localparam logic [1:0] STOP_EOD   = 2'd3;

  typedef struct packed {
    logic        at_start;
    logic        negative;
    logic        in_fraction;
    logic [14:0] whole_part;
    logic [31:0] fraction_sum;
    logic [3:0]  fraction_digits;
    logic        clamped;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    at_start:        1'b1,
    negative:        1'b0,
    in_fraction:     1'b0,
    whole_part:      15'd0,
    fraction_sum:    32'd0,
    fraction_digits: 4'd0,
    clamped:         1'b0
  };

  typedef struct packed {
    logic [31:0] fixed_value;
    logic [1:0]  stop_kind;
    logic        saturated;
  } result_t;

  // floor(2^32 / 10^(k+1))
  function automatic logic [31:0] tenth_power(input logic [3:0] k);
    logic [31:0] v;
    unique case (k)
      4'd0:    v = 32'd429496729;
      4'd1:    v = 32'd42949672;
      4'd2:    v = 32'd4294967;
      4'd3:    v = 32'd429496;
      4'd4:    v = 32'd42949;
      4'd5:    v = 32'd4294;
      4'd6:    v = 32'd429;
      4'd7:    v = 32'd42;
      4'd8:    v = 32'd4;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/adf_step.sv */
// ----------------------------------------------------------------------------
// adf_step
// next parse state and result for one text byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adf_step
  import adf_pkg::*;
(
  input  wire logic [7:0]   text_byte,
  input  wire parse_state_t cur,
  output parse_state_t      nxt,
  output logic              emit,
  output result_t           res
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [18:0] whole_wide;
  logic [14:0] whole_sat;
  logic        whole_ovf;
  logic        frac_take;
  logic [35:0] frac_prod;
  logic [32:0] frac_round;
  logic [32:0] mag;
  logic [31:0] mag_sat;
  logic [31:0] fin_value;
  logic [1:0]  kind;
  parse_state_t dig_state;

  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign digit    = 4'(text_byte - CH_ZERO);

  // integer digit: whole * 10 + d with clamp
  assign whole_wide = ({4'd0, cur.whole_part} << 3) + ({4'd0, cur.whole_part} << 1)
                    + {15'd0, digit};
  assign whole_ovf  = whole_wide > {4'd0, WHOLE_LIMIT};
  assign whole_sat  = whole_ovf ? WHOLE_LIMIT : whole_wide[14:0];

  // fraction digit: d * 10^-(k+1) scaled by 2^32, k = fraction digits taken so far
  assign frac_take = (32'(cur.fraction_digits) < 32'(MAX_FRACTION_DIGITS))
                  && (32'(cur.fraction_digits) < 32'(TABLE_LEN));
  assign frac_prod = {32'd0, digit} * {4'd0, tenth_power(cur.fraction_digits)};

  always_comb begin
    dig_state = cur;
    dig_state.at_start = 1'b0;
    if (cur.in_fraction) begin
      if (frac_take) begin
        dig_state.fraction_sum    = cur.fraction_sum + frac_prod[31:0];
        dig_state.fraction_digits = cur.fraction_digits + 4'd1;
      end
    end else begin
      dig_state.whole_part = whole_sat;
      if (whole_ovf) begin
        dig_state.clamped = 1'b1;
      end
    end
  end

  // value of the number held so far
  assign frac_round = {1'b0, cur.fraction_sum} + 33'h0_0000_8000;
  assign mag        = {2'b0, cur.whole_part, 16'd0} + {16'd0, frac_round[32:16]};
  assign mag_sat    = (mag > {1'b0, MAX_MAG}) ? MAX_MAG : mag[31:0];
  assign fin_value  = cur.negative ? (32'd0 - mag_sat) : mag_sat;

  always_comb begin
    priority if (text_byte == CH_EOD)   kind = STOP_EOD;
    else if (text_byte == CH_NL)        kind = STOP_NL;
    else if (text_byte == CH_SLASH)     kind = STOP_SLASH;
    else                                kind = STOP_OTHER;
  end

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '{fixed_value: fin_value, stop_kind: kind, saturated: cur.clamped};
    if (cur.at_start) begin
      priority if (text_byte == CH_SLASH) begin
        emit = 1'b1;
        res  = '{fixed_value: ONE_Q16, stop_kind: STOP_SLASH, saturated: 1'b0};
        nxt  = STATE_CLEAR;
      end else if (text_byte == CH_EOD) begin
        emit = 1'b1;
        nxt  = STATE_CLEAR;
      end else if (text_byte == CH_MINUS) begin
        nxt.at_start = 1'b0;
        nxt.negative = 1'b1;
      end else if (text_byte == CH_DOT) begin
        nxt.at_start    = 1'b0;
        nxt.in_fraction = 1'b1;
      end else if (is_digit) begin
        nxt = dig_state;
      end else begin
        nxt.at_start = 1'b0;
      end
    end else begin
      priority if (is_digit) begin
        nxt = dig_state;
      end else if (text_byte == CH_DOT) begin
        nxt.in_fraction = 1'b1;
      end else begin
        emit = 1'b1;
        nxt  = STATE_CLEAR;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/adf_out_skid.sv */
// ----------------------------------------------------------------------------
// adf_out_skid
// two-entry result buffer, output register plus skid register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adf_out_skid
  import adf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

/* hdl/ascii_decimal_to_fixed_unit.sv */
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_unit
// decimal text bytes in, signed Q15.16 numbers with terminator kind out
// ----------------------------------------------------------------------------
// output: each result is registered in the output buffer, then shown on out_valid
// throughput: one text byte per cycle while in_stall is low; the parse state update is a
//   single registered pass, and a two-entry output buffer keeps input flowing
// reset: synchronous rst_n clears the parse state and empties the output buffer
`timescale 1ns / 1ps
`default_nettype none

module ascii_decimal_to_fixed_unit
  import adf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_text_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     out_fixed_value,
  output logic [1:0]             out_stop_kind,
  output logic                   out_saturated
);

  parse_state_t state_r, state_nxt;
  logic         emit;
  result_t      res;
  result_t      out_data;
  logic         buf_full;
  logic         in_beat;

  assign in_stall = buf_full;
  assign in_beat  = in_valid && !buf_full;

  adf_step u_step (
    .text_byte (in_text_byte),
    .cur       (state_r),
    .nxt       (state_nxt),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  adf_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_beat && emit),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_fixed_value = out_data.fixed_value;
  assign out_stop_kind   = out_data.stop_kind;
  assign out_saturated   = out_data.saturated;

endmodule

`default_nettype wire
